[sv/ttrrs_pkg.sv]
// ----------------------------------------------------------------------------
// ttrrs_pkg
// Shared codes for the task table scheduler: commands, slot states and
// result status values.
// ----------------------------------------------------------------------------
package ttrrs_pkg;

  localparam logic [2:0] CMD_SPAWN  = 3'd0;
  localparam logic [2:0] CMD_SCHED  = 3'd1;
  localparam logic [2:0] CMD_EXIT   = 3'd2;
  localparam logic [2:0] CMD_REAP   = 3'd3;
  localparam logic [2:0] CMD_LOOKUP = 3'd4;

  localparam logic [1:0] SL_FREE   = 2'd0;
  localparam logic [1:0] SL_READY  = 2'd1;
  localparam logic [1:0] SL_ZOMBIE = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd2;
  localparam logic [1:0] STAT_NOT_ZOMBIE = 2'd3;

endpackage

[sv/task_table_round_robin_scheduler.sv]
// ----------------------------------------------------------------------------
// task_table_round_robin_scheduler
// Task table with spawn, round-robin schedule, exit, reap and pid lookup.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_strobe, and it cannot be held off.
// All slot state sits in one single-port-read memory that is walked one slot
// per cycle by spawn, lookup and schedule. Exit first does a read-modify-write
// of the running slot and then walks the table too, reap reads its slot and
// answers, and unknown commands or a reap of an out-of-range slot answer
// straight from idle. Unknown commands return all-zero results. Pids wrap at
// PID_BITS bits and are reported in their low 16 bits; slot numbers are
// reported in their low 4 bits.
// ----------------------------------------------------------------------------
module task_table_round_robin_scheduler #(
  parameter int TASK_SLOTS = 16,
  parameter int PID_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic [3:0]         in_target_slot,
  input  logic [15:0]        in_target_pid,
  input  logic signed [31:0] in_exit_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [3:0]         out_slot_index,
  output logic [15:0]        out_process_id,
  output logic [1:0]         out_slot_status,
  output logic signed [31:0] out_stored_exit,
  output logic               out_switched,
  output logic [3:0]         out_previous_slot
);

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int IW = (AW > 4) ? AW : 4;
  localparam int PW = (PID_BITS > 16) ? PID_BITS : 16;
  localparam int EW = 2 + PID_BITS + 32;
  localparam logic [AW:0] NSLOTS = (AW + 1)'(TASK_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    return (a == AW'(TASK_SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [3:0] slot4(input logic [AW-1:0] a);
    logic [IW-1:0] t;
    t = IW'(a);
    return t[3:0];
  endfunction

  function automatic logic [15:0] pid16(input logic [PID_BITS-1:0] p);
    logic [PW-1:0] t;
    t = PW'(p);
    return t[15:0];
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [3:0]          tslot_r, tslot_nxt;
  logic [15:0]         tpid_r, tpid_nxt;
  logic [31:0]         xval_r, xval_nxt;
  logic [AW-1:0]       running_r, running_nxt;
  logic [PID_BITS-1:0] pidc_r, pidc_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [AW:0]         iss_r, iss_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;

  logic        strobe_r, strobe_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [15:0] pid_r, pid_nxt;
  logic [1:0]  sstat_r, sstat_nxt;
  logic [31:0] exit_r, exit_nxt;
  logic        sw_r, sw_nxt;
  logic [3:0]  prev_r, prev_nxt;

  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       rd_data;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [1:0]          e_state;
  logic [PID_BITS-1:0] e_pid;
  logic [31:0]         e_exit;
  logic                match;
  logic                hit;
  logic                miss_end;
  logic [IW-1:0]       in_tslot_ext;
  logic [IW-1:0]       tslot_ext;
  logic [AW-1:0]       newrun;

  ttrrs_slot_mem #(
    .SLOTS    (TASK_SLOTS),
    .PID_BITS (PID_BITS),
    .AW       (AW),
    .EW       (EW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (rd_addr),
    .rdata (rd_data),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  assign e_state = rd_data[EW-1 -: 2];
  assign e_pid   = rd_data[32 +: PID_BITS];
  assign e_exit  = rd_data[31:0];
  assign in_tslot_ext = IW'(in_target_slot);
  assign tslot_ext    = IW'(tslot_r);

  always_comb begin
    match = 1'b0;
    priority if (cmd_r == ttrrs_pkg::CMD_SPAWN) begin
      match = (e_state == ttrrs_pkg::SL_FREE);
    end else if (cmd_r == ttrrs_pkg::CMD_LOOKUP) begin
      match = (e_state != ttrrs_pkg::SL_FREE) && (32'(e_pid) == 32'(tpid_r));
    end else begin
      match = (e_state == ttrrs_pkg::SL_READY);
    end
  end

  assign hit      = pend_r && match;
  assign miss_end = pend_r && !match && (iss_r == NSLOTS);
  assign newrun   = hit ? pend_addr_r : running_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tslot_nxt     = tslot_r;
    tpid_nxt      = tpid_r;
    xval_nxt      = xval_r;
    running_nxt   = running_r;
    pidc_nxt      = pidc_r;
    addr_nxt      = addr_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    rd_addr       = addr_r;
    we            = 1'b0;
    waddr         = pend_addr_r;
    wdata         = '0;
    strobe_nxt    = 1'b0;
    status_nxt    = ttrrs_pkg::STAT_OK;
    slot_nxt      = '0;
    pid_nxt       = '0;
    sstat_nxt     = '0;
    exit_nxt      = '0;
    sw_nxt        = 1'b0;
    prev_nxt      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          tslot_nxt = in_target_slot;
          tpid_nxt  = in_target_pid;
          xval_nxt  = in_exit_value;
          iss_nxt   = '0;
          unique case (in_command)
            ttrrs_pkg::CMD_SPAWN, ttrrs_pkg::CMD_LOOKUP: begin
              addr_nxt  = '0;
              state_nxt = S_SCAN;
            end
            ttrrs_pkg::CMD_SCHED: begin
              addr_nxt  = next_slot(running_r);
              state_nxt = S_SCAN;
            end
            ttrrs_pkg::CMD_EXIT: begin
              rd_addr   = running_r;
              state_nxt = S_CHK;
            end
            ttrrs_pkg::CMD_REAP: begin
              if (32'(in_target_slot) < 32'(TASK_SLOTS)) begin
                rd_addr   = in_tslot_ext[AW-1:0];
                state_nxt = S_CHK;
              end else begin
                strobe_nxt = 1'b1;
                status_nxt = ttrrs_pkg::STAT_NOT_ZOMBIE;
                slot_nxt   = in_target_slot;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CHK: begin
        if (cmd_r == ttrrs_pkg::CMD_EXIT) begin
          we        = 1'b1;
          waddr     = running_r;
          wdata     = {ttrrs_pkg::SL_ZOMBIE, e_pid, xval_r};
          addr_nxt  = next_slot(running_r);
          iss_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          strobe_nxt = 1'b1;
          slot_nxt   = tslot_r;
          state_nxt  = S_IDLE;
          if (e_state == ttrrs_pkg::SL_ZOMBIE) begin
            we    = 1'b1;
            waddr = tslot_ext[AW-1:0];
            wdata = '0;
          end else begin
            status_nxt = ttrrs_pkg::STAT_NOT_ZOMBIE;
          end
        end
      end
      S_SCAN: begin
        if (iss_r != NSLOTS) begin
          addr_nxt      = next_slot(addr_r);
          iss_nxt       = iss_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = addr_r;
        end
        if (hit || miss_end) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          priority if (cmd_r == ttrrs_pkg::CMD_SPAWN) begin
            if (hit) begin
              we       = 1'b1;
              waddr    = pend_addr_r;
              wdata    = {ttrrs_pkg::SL_READY, pidc_r, 32'd0};
              pidc_nxt = pidc_r + 1'b1;
              slot_nxt = slot4(pend_addr_r);
              pid_nxt  = pid16(pidc_r);
            end else begin
              status_nxt = ttrrs_pkg::STAT_FULL;
            end
          end else if (cmd_r == ttrrs_pkg::CMD_LOOKUP) begin
            if (hit) begin
              slot_nxt  = slot4(pend_addr_r);
              pid_nxt   = pid16(e_pid);
              sstat_nxt = e_state;
              exit_nxt  = e_exit;
            end else begin
              status_nxt = ttrrs_pkg::STAT_NOT_FOUND;
            end
          end else begin
            running_nxt = newrun;
            slot_nxt    = slot4(newrun);
            sw_nxt      = hit && (pend_addr_r != running_r);
            prev_nxt    = slot4(running_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= '0;
      pidc_r    <= PID_BITS'(2);
      iss_r     <= '0;
      pend_r    <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
      pidc_r    <= pidc_nxt;
      iss_r     <= iss_nxt;
      pend_r    <= pend_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    tslot_r     <= tslot_nxt;
    tpid_r      <= tpid_nxt;
    xval_r      <= xval_nxt;
    addr_r      <= addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    slot_r      <= slot_nxt;
    pid_r       <= pid_nxt;
    sstat_r     <= sstat_nxt;
    exit_r      <= exit_nxt;
    sw_r        <= sw_nxt;
    prev_r      <= prev_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_slot_index    = slot_r;
  assign out_process_id    = pid_r;
  assign out_slot_status   = sstat_r;
  assign out_stored_exit   = $signed(exit_r);
  assign out_switched      = sw_r;
  assign out_previous_slot = prev_r;

`ifndef SYNTHESIS
  a_running_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(running_r) < 32'(TASK_SLOTS))
    else $error("running slot out of range");

  a_unknown_cmd_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command > ttrrs_pkg::CMD_LOOKUP) |=> out_strobe)
    else $error("unknown command got no result");

  a_full_keeps_pid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ttrrs_pkg::STAT_FULL) |-> pidc_r == $past(pidc_r))
    else $error("pid counter moved on a full spawn");
`endif

endmodule

[sv/ttrrs_slot_mem.sv]
// ----------------------------------------------------------------------------
// ttrrs_slot_mem
// Slot table memory: one entry per slot holding state, pid and exit code.
// One write and one registered read per cycle. Per-entry valid bits make
// unwritten entries read as their reset contents.
// ----------------------------------------------------------------------------
module ttrrs_slot_mem #(
  parameter int SLOTS    = 16,
  parameter int PID_BITS = 16,
  parameter int AW       = $clog2(SLOTS),
  parameter int EW       = 2 + PID_BITS + 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata
);

  localparam logic [EW-1:0] ENTRY0 = {ttrrs_pkg::SL_READY, PID_BITS'(1), 32'd0};

  logic [EW-1:0]    mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [EW-1:0]    rdata_r;
  logic             rvld_r;
  logic             rzero_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rvld_r  <= 1'b0;
      rzero_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r  <= vld_r[raddr];
      rzero_r <= (raddr == '0);
    end
  end

  assign rdata = rvld_r ? rdata_r : (rzero_r ? ENTRY0 : '0);

endmodule
